[rtl/sprb_pkg.sv]
// ----------------------------------------------------------------------------
// sprb_pkg
// Shared widths, defaults, register indexes and types of the sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package sprb_pkg;

  localparam int unsigned SCREEN_W_DEF       = 320;
  localparam int unsigned SCREEN_H_DEF       = 200;
  localparam int unsigned MAX_SPRITE_DIM_DEF = 64;

  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned DIM_W     = 7;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned CLIP_X_W  = 9;
  localparam int unsigned CLIP_Y_W  = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 2'd3;

  localparam logic [CLIP_X_W-1:0] CLIP_LEFT_RST   = 9'd0;
  localparam logic [CLIP_Y_W-1:0] CLIP_TOP_RST    = 8'd0;
  localparam logic [CLIP_X_W-1:0] CLIP_RIGHT_RST  = 9'd320;
  localparam logic [CLIP_Y_W-1:0] CLIP_BOTTOM_RST = 8'd200;

  typedef struct packed {
    logic [CLIP_X_W-1:0] left;
    logic [CLIP_Y_W-1:0] top;
    logic [CLIP_X_W-1:0] right;
    logic [CLIP_Y_W-1:0] bottom;
  } clip_t;

endpackage

`default_nettype wire

[rtl/sprb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sprb_cfg_regs
// Clip rectangle registers; right and bottom bounds limited to the screen.
// ----------------------------------------------------------------------------
`default_nettype none

module sprb_cfg_regs #(
  parameter int unsigned SCREEN_W = sprb_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = sprb_pkg::SCREEN_H_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sprb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [sprb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output sprb_pkg::clip_t                        clip_o
);
  import sprb_pkg::*;

  logic [CLIP_X_W-1:0] left_q, right_q;
  logic [CLIP_Y_W-1:0] top_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= CLIP_LEFT_RST;
      top_q    <= CLIP_TOP_RST;
      right_q  <= CLIP_RIGHT_RST;
      bottom_q <= CLIP_BOTTOM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLIP_LEFT:   left_q   <= cfg_wdata_i[CLIP_X_W-1:0];
        CFG_CLIP_TOP:    top_q    <= cfg_wdata_i[CLIP_Y_W-1:0];
        CFG_CLIP_RIGHT:  right_q  <= cfg_wdata_i[CLIP_X_W-1:0];
        CFG_CLIP_BOTTOM: bottom_q <= cfg_wdata_i[CLIP_Y_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    clip_o.left   = left_q;
    clip_o.top    = top_q;
    clip_o.right  = (32'(right_q) > 32'(SCREEN_W)) ? CLIP_X_W'(SCREEN_W) : right_q;
    clip_o.bottom = (32'(bottom_q) > 32'(SCREEN_H)) ? CLIP_Y_W'(SCREEN_H) : bottom_q;
  end

endmodule

`default_nettype wire

[rtl/sprb_raster_cnt.sv]
// ----------------------------------------------------------------------------
// sprb_raster_cnt
// Column and row counters of the sprite raster, with size clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module sprb_raster_cnt #(
  parameter int unsigned MAX_SPRITE_DIM = sprb_pkg::MAX_SPRITE_DIM_DEF,
  localparam int unsigned CW = $clog2(MAX_SPRITE_DIM)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           advance_i,
  input  wire logic                           start_i,
  input  wire logic [sprb_pkg::DIM_W-1:0]     width_i,
  input  wire logic [sprb_pkg::DIM_W-1:0]     height_i,
  output logic [CW-1:0]                       col_o,
  output logic [CW-1:0]                       row_o,
  output logic                                last_o
);
  import sprb_pkg::*;

  localparam int unsigned DW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [DW-1:0] w_eff, h_eff;
  logic          end_row;

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DW-1:0] dw;
    dw = DW'(d);
    if (d == '0) begin
      return DW'(1);
    end else if (dw > DW'(MAX_SPRITE_DIM)) begin
      return DW'(MAX_SPRITE_DIM);
    end
    return dw;
  endfunction

  always_comb begin
    w_eff   = clamp_dim(width_i);
    h_eff   = clamp_dim(height_i);
    col_o   = start_i ? '0 : col_q;
    row_o   = start_i ? '0 : row_q;
    end_row = (DW'(col_o) + DW'(1)) >= w_eff;
    last_o  = end_row && ((DW'(row_o) + DW'(1)) >= h_eff);
    priority if (last_o) begin
      col_d = '0;
      row_d = '0;
    end else if (end_row) begin
      col_d = '0;
      row_d = row_o + CW'(1);
    end else begin
      col_d = col_o + CW'(1);
      row_d = row_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

`ifndef SYNTHESIS
  a_wrap_to_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last_o |=> col_q == '0 && row_q == '0)
    else $error("counters not cleared after last pixel");
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(MAX_SPRITE_DIM) && 32'(row_q) < 32'(MAX_SPRITE_DIM))
    else $error("raster counter beyond sprite size");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(col_q) && $stable(row_q))
    else $error("counters moved without a request");
`endif

endmodule

`default_nettype wire

[rtl/sprb_clip_addr.sv]
// ----------------------------------------------------------------------------
// sprb_clip_addr
// Screen position, clip and transparency test, frame buffer address.
// ----------------------------------------------------------------------------
`default_nettype none

module sprb_clip_addr #(
  parameter int unsigned SCREEN_W       = sprb_pkg::SCREEN_W_DEF,
  parameter int unsigned MAX_SPRITE_DIM = sprb_pkg::MAX_SPRITE_DIM_DEF,
  localparam int unsigned CW = $clog2(MAX_SPRITE_DIM)
) (
  input  wire sprb_pkg::clip_t                 clip_i,
  input  wire logic [sprb_pkg::COLOR_W-1:0]    color_i,
  input  wire logic [sprb_pkg::COORD_W-1:0]    origin_x_i,
  input  wire logic [sprb_pkg::COORD_W-1:0]    origin_y_i,
  input  wire logic [CW-1:0]                   col_i,
  input  wire logic [CW-1:0]                   row_i,
  output logic                                 we_o,
  output logic [sprb_pkg::ADDR_W-1:0]          addr_o,
  output logic [sprb_pkg::COLOR_W-1:0]         color_o
);
  import sprb_pkg::*;

  localparam int unsigned PW = ((CW + 1 > COORD_W) ? CW + 1 : COORD_W) + 1;

  logic signed [PW-1:0] px, py;
  logic signed [PW-1:0] xl, xr, yt, yb;
  logic [ADDR_W-1:0]    row_base;
  logic                 visible;

  always_comb begin
    px = $signed({{(PW-COORD_W){origin_x_i[COORD_W-1]}}, origin_x_i})
       + $signed({{(PW-CW){1'b0}}, col_i});
    py = $signed({{(PW-COORD_W){origin_y_i[COORD_W-1]}}, origin_y_i})
       + $signed({{(PW-CW){1'b0}}, row_i});
    xl = $signed({{(PW-CLIP_X_W){1'b0}}, clip_i.left});
    xr = $signed({{(PW-CLIP_X_W){1'b0}}, clip_i.right});
    yt = $signed({{(PW-CLIP_Y_W){1'b0}}, clip_i.top});
    yb = $signed({{(PW-CLIP_Y_W){1'b0}}, clip_i.bottom});
    visible  = (px >= xl) && (px < xr) && (py >= yt) && (py < yb);
    we_o     = visible && (color_i != '0);
    row_base = ADDR_W'(py) * ADDR_W'(SCREEN_W);
    addr_o   = we_o ? row_base + ADDR_W'(px) : '0;
    color_o  = we_o ? color_i : '0;
  end

endmodule

`default_nettype wire

[rtl/clipped_transparent_sprite_blit_unit.sv]
// ----------------------------------------------------------------------------
// clipped_transparent_sprite_blit_unit
// Sprite pixel stream in, clipped frame buffer write requests out.
// ----------------------------------------------------------------------------
// Input stream: one sprite pixel per request, raster order. tdata carries the
// color, origin and size; tuser marks the first pixel of a sprite.
// Output stream: one write request per input pixel. tuser is the write
// enable, tdata the address and color (both zero when not written), tlast
// marks the final pixel of the sprite.
// Throughput: one pixel per clock while the output takes requests. A pixel
// is held in the input register, then its result in the result register,
// which drives the output (two register stages: an input register and a
// result register, with the counter, clip compare and one constant multiply for the row base between them).
// Stall: each stage holds its request while the one downstream is full, so
// input is taken as long as the input register is free or moving on.
// Reset: clip rectangle to full screen, counters to zero, both stages empty.
// The user writes clip registers through the cfg port while idle; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_transparent_sprite_blit_unit #(
  parameter int unsigned SCREEN_W       = sprb_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H       = sprb_pkg::SCREEN_H_DEF,
  parameter int unsigned MAX_SPRITE_DIM = sprb_pkg::MAX_SPRITE_DIM_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [sprb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [sprb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pixel_color, origin_x, origin_y, sprite_width, sprite_height, zero pad
  input  wire logic [sprb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // start_of_sprite
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // write_address, write_color
  output logic [sprb_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // write_enable
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tlast
);
  import sprb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SPRITE_DIM);

  localparam int unsigned OX_LSB = COLOR_W;
  localparam int unsigned OY_LSB = OX_LSB + COORD_W;
  localparam int unsigned W_LSB  = OY_LSB + COORD_W;
  localparam int unsigned H_LSB  = W_LSB + DIM_W;

  clip_t clip;

  logic               v1_q;
  logic [COLOR_W-1:0] color_q;
  logic [COORD_W-1:0] ox_q, oy_q;
  logic [DIM_W-1:0]   w_q, h_q;
  logic               start_q;

  logic               v2_q;
  logic               we_q, we_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [COLOR_W-1:0] wcolor_q, wcolor_d;
  logic               last_q, last_d;

  logic [CW-1:0]      col, row;
  logic               ready1, adv1, take_in;

  assign ready1        = !v2_q || m_axis_tready;
  assign adv1          = v1_q && ready1;
  assign s_axis_tready = !v1_q || ready1;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  sprb_cfg_regs #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .clip_o      (clip)
  );

  sprb_raster_cnt #(
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_cnt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (adv1),
    .start_i   (start_q),
    .width_i   (w_q),
    .height_i  (h_q),
    .col_o     (col),
    .row_o     (row),
    .last_o    (last_d)
  );

  sprb_clip_addr #(
    .SCREEN_W       (SCREEN_W),
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_clip (
    .clip_i     (clip),
    .color_i    (color_q),
    .origin_x_i (ox_q),
    .origin_y_i (oy_q),
    .col_i      (col),
    .row_i      (row),
    .we_o       (we_d),
    .addr_o     (addr_d),
    .color_o    (wcolor_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        v1_q <= s_axis_tvalid;
      end
      if (ready1) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      color_q <= s_axis_tdata[COLOR_W-1:0];
      ox_q    <= s_axis_tdata[OY_LSB-1:OX_LSB];
      oy_q    <= s_axis_tdata[W_LSB-1:OY_LSB];
      w_q     <= s_axis_tdata[H_LSB-1:W_LSB];
      h_q     <= s_axis_tdata[H_LSB+DIM_W-1:H_LSB];
      start_q <= s_axis_tuser;
    end
    if (adv1) begin
      we_q     <= we_d;
      addr_q   <= addr_d;
      wcolor_q <= wcolor_d;
      last_q   <= last_d;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {wcolor_q, addr_q};
  assign m_axis_tuser  = we_q;
  assign m_axis_tlast  = last_q;

`ifndef SYNTHESIS
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !m_axis_tready |=> v2_q && $stable(addr_q) && $stable(we_q))
    else $error("stalled result lost or changed");
  a_masked_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("suppressed write carries data");
  a_addr_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (SCREEN_W * SCREEN_H > 65536) || (32'(addr_q) < SCREEN_W * SCREEN_H))
    else $error("write address outside frame buffer");
  a_free_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("input refused with empty input register");
`endif

endmodule

`default_nettype wire

[verif/sprb_checker.sv]
// ----------------------------------------------------------------------------
// sprb_checker
// Watches the sprite blitter's pixel and write request streams, predicts each
// frame buffer write from the pixel and the clip rectangle, and compares the
// requests in order, field by field.
// ----------------------------------------------------------------------------
module sprb_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sprb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sprb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // pixel_color, origin_x, origin_y, sprite_width, sprite_height, zero pad
  input  logic [sprb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // start_of_sprite
  input  logic                                s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // write_address, write_color
  input  logic [sprb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // write_enable
  input  logic                                m_axis_tuser,
  input  logic                                m_axis_tlast,
  output int                                  err_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sprb_pkg::*;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [COLOR_W-1:0] color;
    logic              last;
  } fb_write_t;

  fb_write_t write_q[$];
  int clip_l = int'(CLIP_LEFT_RST);
  int clip_tp = int'(CLIP_TOP_RST);
  int clip_r = int'(CLIP_RIGHT_RST);
  int clip_b = int'(CLIP_BOTTOM_RST);
  logic [5:0] col_q = '0;
  logic [5:0] row_q = '0;
  int errs = 0;

  initial begin
    err_count_o = 0;
    pending_o = 0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errs++;
  endtask

  function automatic int clamp_size(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > int'(MAX_SPRITE_DIM_DEF)) return int'(MAX_SPRITE_DIM_DEF);
    return int'(v);
  endfunction

  // Advance the sprite counters and return the write request for one pixel.
  function automatic fb_write_t blit_pixel(input logic [IN_TDATA_W-1:0] px_data,
                                           input logic sos);
    fb_write_t res;
    logic [COLOR_W-1:0] color;
    int ox, oy, w, h, col, row, sx, sy, xr, yb;
    logic end_row, end_spr, visible;
    color = px_data[7:0];
    ox = $signed(px_data[17:8]);
    oy = $signed(px_data[27:18]);
    w = clamp_size(px_data[34:28]);
    h = clamp_size(px_data[41:35]);
    if (sos) begin
      col_q = '0;
      row_q = '0;
    end
    col = int'(col_q);
    row = int'(row_q);
    sx = ox + col;
    sy = oy + row;
    xr = (clip_r > int'(SCREEN_W_DEF)) ? int'(SCREEN_W_DEF) : clip_r;
    yb = (clip_b > int'(SCREEN_H_DEF)) ? int'(SCREEN_H_DEF) : clip_b;
    visible = (sx >= clip_l) && (sx < xr) && (sy >= clip_tp) && (sy < yb);
    end_row = (col + 1 >= w);
    end_spr = end_row && (row + 1 >= h);
    res = '0;
    if (visible && color != '0) begin
      res.we = 1'b1;
      res.addr = ADDR_W'(sy * int'(SCREEN_W_DEF) + sx);
      res.color = color;
    end
    res.last = end_spr;
    if (end_spr) begin
      col_q = '0;
      row_q = '0;
    end else if (end_row) begin
      col_q = '0;
      row_q = 6'(row + 1);
    end else begin
      col_q = 6'(col + 1);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    fb_write_t want, got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CLIP_LEFT:   clip_l = int'(cfg_wdata_i[CLIP_X_W-1:0]);
          CFG_CLIP_TOP:    clip_tp = int'(cfg_wdata_i[CLIP_Y_W-1:0]);
          CFG_CLIP_RIGHT:  clip_r = int'(cfg_wdata_i[CLIP_X_W-1:0]);
          CFG_CLIP_BOTTOM: clip_b = int'(cfg_wdata_i[CLIP_Y_W-1:0]);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.we = m_axis_tuser;
        got.addr = m_axis_tdata[15:0];
        got.color = m_axis_tdata[23:16];
        got.last = m_axis_tlast;
        if (write_q.size() == 0) begin
          report_error($sformatf("write request with none expected: %h", got));
        end else begin
          want = write_q.pop_front();
          if (got.we !== want.we)
            report_error($sformatf("write_enable %b, expected %b", got.we, want.we));
          if (got.addr !== want.addr)
            report_error($sformatf("write_address %0d, expected %0d",
                                   got.addr, want.addr));
          if (got.color !== want.color)
            report_error($sformatf("write_color %0d, expected %0d",
                                   got.color, want.color));
          if (got.last !== want.last)
            report_error($sformatf("last_pixel %b, expected %b", got.last, want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        write_q.push_back(blit_pixel(s_axis_tdata, s_axis_tuser));
      end
    end
    pending_o <= write_q.size();
    err_count_o <= errs;
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives sprite pixel streams into the blitter under several clip rectangles,
// with random gaps and output stalls; the checker predicts and compares every
// write request, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sprb_pkg::*;

  localparam int IDLE_LIMIT        = 2000;
  localparam int ITEMS_PER_SETTING = 250;
  localparam int NUM_SETTINGS      = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int errors;
  int pending;
  int n_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  clipped_transparent_sprite_blit_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  sprb_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .err_count_o   (errors),
    .pending_o     (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Randomly stall the write request stream after each request.
  always @(posedge clk or negedge rst_n) begin
    int n;
    if (!rst_n) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready <= (stall_left == 1);
      end else if (m_tvalid && m_tready) begin
        if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
        n = rx_quiet ? 0 : $urandom_range(0, 3);
        stall_left <= n;
        m_tready <= (n == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_pixel(input int color, input int ox, input int oy,
                            input int w, input int h, input bit sos);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, 7'(h), 7'(w), 10'(oy), 10'(ox), 8'(color)};
    s_tuser <= sos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic set_clip(input int l, input int t, input int r, input int b);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_CLIP_LEFT;
    cfg_wdata <= CFG_DATA_W'(l);
    @(posedge clk);
    cfg_idx <= CFG_CLIP_TOP;
    cfg_wdata <= CFG_DATA_W'(t);
    @(posedge clk);
    cfg_idx <= CFG_CLIP_RIGHT;
    cfg_wdata <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_idx <= CFG_CLIP_BOTTOM;
    cfg_wdata <= CFG_DATA_W'(b);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Mostly whole sprites near the screen; some truncated, resized or noise.
  task automatic blit_random_sprite();
    int w, h, ox, oy, n, cut, bend, k, c;
    bit sos;
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        send_pixel($urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 1));
      end
    end else begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) == 1) w = $urandom_range(9, 64);
        else h = $urandom_range(9, 64);
      end
      if ($urandom_range(0, 3) == 0) begin
        ox = $urandom_range(0, 1023) - 512;
        oy = $urandom_range(0, 1023) - 512;
      end else begin
        ox = $urandom_range(0, 420) - 80;
        oy = $urandom_range(0, 300) - 80;
      end
      n = w * h;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
      bend = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : n;
      for (k = 0; k < cut; k++) begin
        if (k == bend) begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 8);
        end
        c = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
        sos = (k == 0) && ($urandom_range(0, 15) != 0);
        send_pixel(c, ox, oy, w, h, sos);
      end
    end
  endtask

  initial begin
    int base;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels under the full-screen reset rectangle.
    send_pixel(255, 0, 0, 1, 1, 1'b1);
    send_pixel(0, 0, 0, 1, 1, 1'b1);
    send_pixel(128, 319, 199, 1, 1, 1'b1);
    send_pixel(7, 5, 5, 0, 0, 1'b1);
    send_pixel(9, -512, -512, 1, 1, 1'b1);
    send_pixel(9, 511, 511, 1, 1, 1'b1);
    send_pixel(1, 318, 198, 2, 2, 1'b1);
    send_pixel(2, 318, 198, 2, 2, 1'b0);
    send_pixel(3, 318, 198, 2, 2, 1'b0);
    send_pixel(4, 318, 198, 2, 2, 1'b0);
    send_pixel(10, -1, -1, 4, 4, 1'b1);
    send_pixel(11, -1, -1, 4, 4, 1'b0);
    send_pixel(12, -1, -1, 4, 4, 1'b0);
    send_pixel(13, -1, -1, 1, 4, 1'b0);
    send_pixel(14, -1, -1, 1, 1, 1'b0);
    send_pixel(15, 40, 30, 127, 127, 1'b1);
    send_pixel(16, 40, 30, 127, 127, 1'b0);
    send_pixel(17, 40, 30, 1, 1, 1'b1);
    send_pixel(20, 100, 100, 2, 1, 1'b0);
    send_pixel(21, 100, 100, 2, 1, 1'b0);
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: set_clip(0, 0, 320, 200);
        1: set_clip(319, 199, 320, 200);
        2: set_clip(200, 100, 100, 50);
        3: set_clip(0, 0, 511, 255);
        4: set_clip(150, 90, 150, 90);
        5: set_clip(0, 0, 1, 1);
        default: set_clip($urandom_range(0, 319), $urandom_range(0, 199),
                          $urandom_range(1, 320), $urandom_range(1, 200));
      endcase
      base = n_sent;
      while (n_sent - base < ITEMS_PER_SETTING) blit_random_sprite();
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[clipped_transparent_sprite_blit_unit.f]
rtl/sprb_pkg.sv
rtl/sprb_cfg_regs.sv
rtl/sprb_raster_cnt.sv
rtl/sprb_clip_addr.sv
rtl/clipped_transparent_sprite_blit_unit.sv
verif/sprb_checker.sv
verif/tb.sv
